### src/credit_based_shaper_core_assert.svh
// Assertion helpers for the shaper core; clock i_clk, reset i_rst_n.
`ifndef CREDIT_BASED_SHAPER_CORE_ASSERT_SVH
`define CREDIT_BASED_SHAPER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CBS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/cbs_pkg.sv
package cbs_pkg;

    localparam int TIME_W       = 64;
    localparam int BYTES_W      = 14;
    localparam int CREDIT_W     = 44;
    localparam int CREDIT_OUT_W = 43;
    localparam int HI_W         = 42;
    localparam int LO_W         = 43;
    localparam int IGAIN_W      = 10;
    localparam int SGAIN_W      = 11;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 43;

    localparam int DUR_W        = 17;
    localparam int ELAPSED_W    = 44;
    localparam int PROD_W       = ELAPSED_W + IGAIN_W;
    localparam int SPROD_W      = DUR_W + 1 + SGAIN_W;
    localparam int SUM_W        = PROD_W + 2;
    localparam int C2_W         = CREDIT_W + 1;
    localparam int QUO_W        = 43;

    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 112;
    localparam int OUT_PAD_W    = OUT_TDATA_W - CREDIT_OUT_W - TIME_W;

    localparam int MIN_FRAME_BYTES = 60;

    localparam longint unsigned NS_PER_SECOND = 64'd1000000000;
    localparam longint unsigned LINK_BPS      = 64'd1000000000;
    localparam longint unsigned BITS_PER_BYTE = 64'd8;
    localparam longint unsigned DUR_SCALE     = BITS_PER_BYTE * NS_PER_SECOND / LINK_BPS;

    typedef enum logic [STATUS_W-1:0] {
        STS_UPDATED  = 2'd0,
        STS_DISABLED = 2'd1,
        STS_REJECTED = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 3'd0,
        REG_HIGH   = 3'd1,
        REG_LOW    = 3'd2,
        REG_IDLE   = 3'd3,
        REG_SEND   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic load_in;
        logic check;
        logic mul;
        logic add;
        logic spend;
        logic div_start;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic neg;
        logic div_done;
    } t_sts;

endpackage

### src/credit_based_shaper_core.sv
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   frame send
// m_axis    out        m_axis_tvalid / m_axis_tready   status, credit, next available
// cfg       in         i_cfg_valid / o_cfg_ready       register index and data
//
// One transaction at a time. A disabled or rejected frame skips the credit update;
// an updated credit that goes negative also runs the 43-step credit/idle-gain
// divider, the longest case.
// A new frame is taken while the previous result waits in the output register.
// Synchronous active-low reset clears credit, times and config registers to their defaults.
`include "credit_based_shaper_core_assert.svh"

module credit_based_shaper_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [63:0] start_time, [77:64] frame_bytes
    input  logic [cbs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [42:0] credit_now, [106:43] next_available
    output logic [cbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [cbs_pkg::STATUS_W-1:0]    m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cbs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = i_rst_n;

    cbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    cbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_user  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

    `CBS_ASSERT_NEXT(a_single_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second frame taken mid-update")
    `CBS_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(w_cmd), "more than one datapath command")
    `CBS_ASSERT_NEXT(a_out_loaded, w_cmd.out_load, m_axis_tvalid, "result loaded but not presented")
    `CBS_ASSERT_NOW(a_div_neg, w_cmd.div_start, w_sts.neg, "divider started for non-negative credit")

endmodule

### src/cbs_div.sv
module cbs_div #(
    parameter int N_W = cbs_pkg::QUO_W,
    parameter int D_W = cbs_pkg::IGAIN_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic [N_W-1:0] o_quotient,
    output logic           o_done
);
    import cbs_pkg::*;

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   r_quo;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [D_W:0] w_trial;
    logic [D_W:0] w_diff;
    logic         w_ge;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quo[N_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(N_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[N_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[D_W-1:0] : w_trial[D_W-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

### src/cbs_dp.sv
module cbs_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [cbs_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  cbs_pkg::t_cmd                    i_cmd,
    output cbs_pkg::t_sts                    o_sts,
    output logic [cbs_pkg::STATUS_W-1:0]     o_out_user,
    output logic [cbs_pkg::OUT_TDATA_W-1:0]  o_out_data
);
    import cbs_pkg::*;

    // configuration
    logic                      r_enable;
    logic [HI_W-1:0]           r_hi;
    logic signed [LO_W-1:0]    r_lo;
    logic [IGAIN_W-1:0]        r_igain;
    logic signed [SGAIN_W-1:0] r_sgain;

    // shaper state
    logic signed [CREDIT_W-1:0] r_credit;
    logic [TIME_W-1:0]          r_last;
    logic [TIME_W-1:0]          r_avail;

    // per-transaction working registers
    logic [TIME_W-1:0]          r_at;
    logic [BYTES_W-1:0]         r_bytes;
    t_status                    r_status;
    logic [ELAPSED_W-1:0]       r_elapsed;
    logic                       r_big;
    logic [DUR_W-1:0]           r_dur;
    logic [PROD_W-1:0]          r_prod;
    logic signed [SPROD_W-1:0]  r_sprod;
    logic signed [CREDIT_W-1:0] r_c1;
    logic signed [CREDIT_W-1:0] r_cnew;
    logic [TIME_W-1:0]          r_tx_end;
    logic                       r_neg;

    // output register
    t_status                    r_o_status;
    logic [CREDIT_OUT_W-1:0]    r_o_credit;
    logic [TIME_W-1:0]          r_o_next;

    logic [IGAIN_W-1:0]         w_gain;
    logic [BYTES_W-1:0]         w_pad;
    logic [DUR_W-1:0]           w_dur;
    logic                       w_reject;
    logic [TIME_W-1:0]          w_elapsed;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [SUM_W-1:0]    w_hi_s;
    logic signed [CREDIT_W-1:0] w_c1;
    logic signed [C2_W-1:0]     w_c2;
    logic signed [C2_W-1:0]     w_lo_s;
    logic signed [C2_W-1:0]     w_cnew;
    logic signed [CREDIT_W-1:0] w_neg_credit;
    logic [QUO_W-1:0]           w_quo;
    logic                       w_div_done;
    logic [CREDIT_OUT_W-1:0]    w_cout;

    assign w_gain = (r_igain == '0) ? IGAIN_W'(1) : r_igain;

    assign w_pad = (r_bytes < BYTES_W'(MIN_FRAME_BYTES)) ? BYTES_W'(MIN_FRAME_BYTES) : r_bytes;
    assign w_dur = DUR_W'(w_pad) * DUR_W'(DUR_SCALE);

    assign w_reject  = (r_at < r_last) || (r_at < r_avail);
    assign w_elapsed = r_at - r_last;

    // earn, then clamp at the high limit
    assign w_sum  = SUM_W'(r_credit) + SUM_W'(r_prod);
    assign w_hi_s = $signed(SUM_W'(r_hi));
    assign w_c1   = (r_big || (w_sum > w_hi_s)) ? CREDIT_W'(r_hi) : w_sum[CREDIT_W-1:0];

    // spend, then clamp at the low limit
    assign w_c2   = C2_W'(r_c1) + C2_W'(r_sprod);
    assign w_lo_s = C2_W'(r_lo);
    assign w_cnew = (w_c2 < w_lo_s) ? w_lo_s : w_c2;

    assign w_neg_credit = -r_cnew;

    cbs_div #(
        .N_W (QUO_W),
        .D_W (IGAIN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_neg_credit[QUO_W-1:0]),
        .i_divisor  (w_gain),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // saturate to the reported width
    always_comb begin
        if (r_credit[CREDIT_W-1] == r_credit[CREDIT_W-2]) begin
            w_cout = r_credit[CREDIT_OUT_W-1:0];
        end else if (r_credit[CREDIT_W-1]) begin
            w_cout = {1'b1, {(CREDIT_OUT_W-1){1'b0}}};
        end else begin
            w_cout = {1'b0, {(CREDIT_OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_hi     <= '0;
            r_lo     <= '0;
            r_igain  <= IGAIN_W'(1);
            r_sgain  <= '0;
            r_credit <= '0;
            r_last   <= '0;
            r_avail  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    REG_ENABLE: r_enable <= i_cfg_data[0];
                    REG_HIGH:   r_hi     <= i_cfg_data[HI_W-1:0];
                    REG_LOW:    r_lo     <= i_cfg_data[LO_W-1:0];
                    REG_IDLE:   r_igain  <= i_cfg_data[IGAIN_W-1:0];
                    REG_SEND:   r_sgain  <= i_cfg_data[SGAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.commit) begin
                r_credit <= r_cnew;
                r_last   <= r_tx_end;
                r_avail  <= r_neg ? r_tx_end + TIME_W'(w_quo) : r_tx_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_at    <= i_in_data[TIME_W-1:0];
            r_bytes <= i_in_data[TIME_W +: BYTES_W];
        end
        if (i_cmd.check) begin
            if (!r_enable) begin
                r_status <= STS_DISABLED;
            end else if (w_reject) begin
                r_status <= STS_REJECTED;
            end else begin
                r_status <= STS_UPDATED;
            end
            r_elapsed <= w_elapsed[ELAPSED_W-1:0];
            r_big     <= |w_elapsed[TIME_W-1:ELAPSED_W];
            r_dur     <= w_dur;
        end
        if (i_cmd.mul) begin
            r_prod  <= r_elapsed * w_gain;
            r_sprod <= $signed({1'b0, r_dur}) * r_sgain;
        end
        if (i_cmd.add) begin
            r_c1 <= w_c1;
        end
        if (i_cmd.spend) begin
            r_cnew   <= w_cnew[CREDIT_W-1:0];
            r_neg    <= w_cnew[C2_W-1];
            r_tx_end <= r_at + TIME_W'(r_dur);
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_credit <= w_cout;
            r_o_next   <= r_avail;
        end
    end

    assign o_sts.skip     = (r_status != STS_UPDATED);
    assign o_sts.neg      = r_neg;
    assign o_sts.div_done = w_div_done;

    assign o_out_user = r_o_status;
    assign o_out_data = {{OUT_PAD_W{1'b0}}, r_o_next, r_o_credit};

endmodule

### src/cbs_ctrl.sv
module cbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output cbs_pkg::t_cmd o_cmd,
    input  cbs_pkg::t_sts i_sts
);
    import cbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_ADD,
        S_SPEND,
        S_DIV_GO,
        S_DIV_WAIT,
        S_COMMIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                if (i_sts.skip) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = S_SPEND;
            end
            S_SPEND: begin
                o_cmd.spend = 1'b1;
                n_state     = S_DIV_GO;
            end
            S_DIV_GO: begin
                if (i_sts.neg) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV_WAIT;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
